@@ hdl/wpid_pkg.sv @@
// wpid_pkg: shared types and constants for the two-axis waypoint pid controller
// used by the lane, merge and top-level modules under hdl
package wpid_pkg;

  localparam int unsigned DIV_STEPS = 29;
  localparam int unsigned CNT_W = 5;
  localparam logic [1:0] WP_DONE = 2'd3;

  localparam logic [2:0] CFG_GAIN_P = 3'd0;
  localparam logic [2:0] CFG_GAIN_I = 3'd1;
  localparam logic [2:0] CFG_GAIN_D = 3'd2;
  localparam logic [2:0] CFG_TOL = 3'd3;
  localparam logic [2:0] CFG_TGT0 = 3'd4;
  localparam logic [2:0] CFG_TGT1 = 3'd5;
  localparam logic [2:0] CFG_TGT2 = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_INTEG,
    ST_DIV,
    ST_MUL2,
    ST_SUM,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic integ;
    logic div_step;
    logic mul2;
    logic sum;
    logic commit;
    logic emit;
    logic arrive;
  } lane_ctl_t;

endpackage

@@ hdl/wpid_lane.sv @@
// wpid_lane: one axis of the controller, error, saturating integral,
// serial rate divider and gain products; depends on wpid_pkg
module wpid_lane (
  input  logic                    clk,
  input  logic                    rst_n,
  input  wpid_pkg::lane_ctl_t     ctl,
  input  logic signed [15:0]      pose,
  input  logic signed [15:0]      target,
  input  logic [15:0]             elapsed,
  input  logic signed [15:0]      gain_p,
  input  logic signed [15:0]      gain_i,
  input  logic signed [15:0]      gain_d,
  output logic [32:0]             sq,
  output logic signed [15:0]      cmd
);

  logic signed [16:0] ex_r, diff_r;
  logic signed [15:0] pose_r, last_r;
  logic [15:0]        dt_r;
  logic [32:0]        sq_r;
  logic signed [33:0] prod_r;
  logic signed [32:0] pterm_r;
  logic signed [39:0] integ_r, integ_new_r;
  logic [28:0]        nq_r;
  logic [15:0]        rem_r;
  logic               neg_r;
  logic signed [55:0] iterm_r;
  logic signed [45:0] dterm_r;
  logic signed [15:0] cmd_r;

  logic signed [33:0] pr_sq, pr_dt;
  logic signed [32:0] pr_p;
  logic signed [40:0] isum;
  logic signed [39:0] isat;
  logic [16:0]        diff_mag;
  logic [16:0]        rem_sh;
  logic               q_bit;
  logic signed [29:0] rate;
  logic signed [59:0] acc, rnd;
  logic signed [35:0] qv;
  logic signed [15:0] cmd_c;

  always_comb begin
    pr_sq = ex_r * ex_r;
    pr_dt = ex_r * $signed({1'b0, dt_r});
    pr_p = gain_p * ex_r;
    isum = 41'(integ_r) + 41'(prod_r);
    if (isum[40] != isum[39]) begin
      isat = isum[40] ? {1'b1, {39{1'b0}}} : {1'b0, {39{1'b1}}};
    end else begin
      isat = isum[39:0];
    end
    diff_mag = diff_r[16] ? 17'(-diff_r) : 17'(diff_r);
    rem_sh = {rem_r, nq_r[28]};
    q_bit = rem_sh >= {1'b0, dt_r};
    if (dt_r == 16'd0) begin
      rate = '0;
    end else if (neg_r) begin
      rate = -$signed({1'b0, nq_r});
    end else begin
      rate = $signed({1'b0, nq_r});
    end
    acc = (60'(pterm_r) <<< 12) + 60'(iterm_r) + (60'(dterm_r) <<< 12);
    rnd = acc + 60'sd8388608;
    qv = rnd[59:24];
    if (qv > 36'sd32767) begin
      cmd_c = 16'sd32767;
    end else if (qv < -36'sd32768) begin
      cmd_c = -16'sd32768;
    end else begin
      cmd_c = qv[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      last_r <= '0;
    end else if (ctl.commit) begin
      integ_r <= ctl.arrive ? '0 : integ_new_r;
      last_r <= pose_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ex_r <= {target[15], target} - {pose[15], pose};
      diff_r <= {pose[15], pose} - {last_r[15], last_r};
      pose_r <= pose;
      dt_r <= elapsed;
    end
    if (ctl.mul1) begin
      sq_r <= pr_sq[32:0];
      prod_r <= pr_dt;
      pterm_r <= pr_p;
    end
    if (ctl.integ) begin
      integ_new_r <= isat;
      nq_r <= {diff_mag[16:0], 12'd0};
      neg_r <= diff_r[16];
      rem_r <= '0;
    end
    if (ctl.div_step) begin
      rem_r <= q_bit ? 16'(rem_sh - {1'b0, dt_r}) : rem_sh[15:0];
      nq_r <= {nq_r[27:0], q_bit};
    end
    if (ctl.mul2) begin
      iterm_r <= gain_i * integ_new_r;
      dterm_r <= gain_d * rate;
    end
    if (ctl.sum) begin
      cmd_r <= cmd_c;
    end
  end

  assign sq = sq_r;
  assign cmd = cmd_r;

endmodule

@@ hdl/wpid_merge.sv @@
// wpid_merge: arrival test on both lanes, waypoint index and result word
// registers; depends on wpid_pkg
module wpid_merge (
  input  logic                    clk,
  input  logic                    rst_n,
  input  wpid_pkg::lane_ctl_t     ctl,
  input  logic [15:0]             tol,
  input  logic [32:0]             sq_x,
  input  logic [32:0]             sq_y,
  input  logic signed [15:0]      cmd_x,
  input  logic signed [15:0]      cmd_y,
  output logic [1:0]              idx,
  output logic                    arrive,
  output logic signed [15:0]      out_x,
  output logic signed [15:0]      out_y,
  output logic [1:0]              out_idx,
  output logic                    out_done
);

  logic [31:0]        tol2_r;
  logic               arrive_r;
  logic [1:0]         idx_r, idx_nxt;
  logic signed [15:0] ox_r, oy_r;
  logic [1:0]         oidx_r;
  logic               zero_cmd;

  always_comb begin
    idx_nxt = (ctl.commit && ctl.arrive) ? 2'(idx_r + 2'd1) : idx_r;
    zero_cmd = (idx_r == wpid_pkg::WP_DONE) || arrive_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul1) begin
      tol2_r <= tol * tol;
    end
    if (ctl.integ) begin
      arrive_r <= (34'(sq_x) + 34'(sq_y)) < 34'(tol2_r);
    end
    if (ctl.emit) begin
      ox_r <= zero_cmd ? '0 : cmd_x;
      oy_r <= zero_cmd ? '0 : cmd_y;
      oidx_r <= idx_nxt;
    end
  end

  assign idx = idx_r;
  assign arrive = arrive_r;
  assign out_x = ox_r;
  assign out_y = oy_r;
  assign out_idx = oidx_r;
  assign out_done = oidx_r == wpid_pkg::WP_DONE;

endmodule

@@ hdl/waypoint_pid_2d.sv @@
// waypoint_pid_2d: top level of the two-axis waypoint pid controller
// instantiates wpid_lane (x and y) and wpid_merge; depends on wpid_pkg
//
// One result word per input word. After a word is accepted the steps are:
// error products, integral update, a restoring divider with a 29-bit
// quotient for the position rate (one quotient bit per cycle in each lane),
// gain products, sum and rounding, then the result load, which waits while
// out_stall holds an earlier result. The next word can be accepted in the
// cycle after the result load. The block holds one word at a time; in_stall
// is high from the cycle after acceptance until the result is loaded, and
// the result waits in its register until taken.
module waypoint_pid_2d (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_pose_x,
  input  logic signed [15:0] in_pose_y,
  input  logic [15:0]        in_elapsed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_cmd_x,
  output logic signed [15:0] out_cmd_y,
  output logic [1:0]         out_target_index,
  output logic               out_mission_done,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  wpid_pkg::state_t    state_r, state_nxt;
  logic [wpid_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  wpid_pkg::lane_ctl_t ctl;
  logic                out_valid_r, out_valid_nxt;

  logic signed [15:0] gain_p_r, gain_i_r, gain_d_r;
  logic [15:0]        tol_r;
  logic [31:0]        tgt0_r, tgt1_r, tgt2_r, tgt_sel;

  logic [1:0]         idx;
  logic               arrive;
  logic [32:0]        sq_x, sq_y;
  logic signed [15:0] cmd_x, cmd_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= 16'sd1229;
      gain_i_r <= 16'sd41;
      gain_d_r <= 16'sd4096;
      tol_r <= 16'd20;
      tgt0_r <= 32'd1024;
      tgt1_r <= 32'd2048;
      tgt2_r <= 32'd3072;
    end else if (cfg_we) begin
      case (cfg_index)
        wpid_pkg::CFG_GAIN_P: gain_p_r <= cfg_wdata[15:0];
        wpid_pkg::CFG_GAIN_I: gain_i_r <= cfg_wdata[15:0];
        wpid_pkg::CFG_GAIN_D: gain_d_r <= cfg_wdata[15:0];
        wpid_pkg::CFG_TOL: tol_r <= cfg_wdata[15:0];
        wpid_pkg::CFG_TGT0: tgt0_r <= cfg_wdata;
        wpid_pkg::CFG_TGT1: tgt1_r <= cfg_wdata;
        wpid_pkg::CFG_TGT2: tgt2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      2'd0: tgt_sel = tgt0_r;
      2'd1: tgt_sel = tgt1_r;
      default: tgt_sel = tgt2_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wpid_pkg::ST_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    ctl = '0;
    ctl.arrive = arrive;
    case (state_r)
      wpid_pkg::ST_IDLE: begin
        if (in_valid) begin
          ctl.load = 1'b1;
          state_nxt = wpid_pkg::ST_MUL1;
        end
      end
      wpid_pkg::ST_MUL1: begin
        ctl.mul1 = 1'b1;
        state_nxt = wpid_pkg::ST_INTEG;
      end
      wpid_pkg::ST_INTEG: begin
        ctl.integ = 1'b1;
        cnt_nxt = '0;
        state_nxt = wpid_pkg::ST_DIV;
      end
      wpid_pkg::ST_DIV: begin
        ctl.div_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == wpid_pkg::CNT_W'(wpid_pkg::DIV_STEPS - 1)) begin
          state_nxt = wpid_pkg::ST_MUL2;
        end
      end
      wpid_pkg::ST_MUL2: begin
        ctl.mul2 = 1'b1;
        state_nxt = wpid_pkg::ST_SUM;
      end
      wpid_pkg::ST_SUM: begin
        ctl.sum = 1'b1;
        state_nxt = wpid_pkg::ST_OUT;
      end
      wpid_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          ctl.emit = 1'b1;
          ctl.commit = idx != wpid_pkg::WP_DONE;
          out_valid_nxt = 1'b1;
          state_nxt = wpid_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wpid_pkg::ST_IDLE;
    endcase
  end

  wpid_lane u_lane_x (
    .clk(clk), .rst_n(rst_n), .ctl(ctl),
    .pose(in_pose_x), .target(tgt_sel[15:0]), .elapsed(in_elapsed),
    .gain_p(gain_p_r), .gain_i(gain_i_r), .gain_d(gain_d_r),
    .sq(sq_x), .cmd(cmd_x)
  );

  wpid_lane u_lane_y (
    .clk(clk), .rst_n(rst_n), .ctl(ctl),
    .pose(in_pose_y), .target(tgt_sel[31:16]), .elapsed(in_elapsed),
    .gain_p(gain_p_r), .gain_i(gain_i_r), .gain_d(gain_d_r),
    .sq(sq_y), .cmd(cmd_y)
  );

  wpid_merge u_merge (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .tol(tol_r),
    .sq_x(sq_x), .sq_y(sq_y), .cmd_x(cmd_x), .cmd_y(cmd_y),
    .idx(idx), .arrive(arrive),
    .out_x(out_cmd_x), .out_y(out_cmd_y),
    .out_idx(out_target_index), .out_done(out_mission_done)
  );

  assign in_stall = state_r != wpid_pkg::ST_IDLE;
  assign out_valid = out_valid_r;

endmodule

@@ hdl/wpid_checker.sv @@
// wpid_checker: port-level assertions for waypoint_pid_2d
// bound to the top level below; no package use
module wpid_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_cmd_x,
  input logic signed [15:0] out_cmd_y,
  input logic [1:0]         out_target_index,
  input logic               out_mission_done
);

  a_done_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mission_done == (out_target_index == 2'd3)))
    else $error("done flag disagrees with index");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_mission_done) |-> (out_cmd_x == 16'sd0 && out_cmd_y == 16'sd0))
    else $error("nonzero command after mission end");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again while busy");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_cmd_x) && $stable(out_cmd_y)))
    else $error("stalled result changed");

endmodule

bind waypoint_pid_2d wpid_checker u_wpid_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_cmd_x(out_cmd_x), .out_cmd_y(out_cmd_y),
  .out_target_index(out_target_index), .out_mission_done(out_mission_done)
);
